[rtl/png_pkg.sv]
// Shared constants and types for the pair net grouper.
`timescale 1ns / 1ps
package png_pkg;

	localparam int POINT_COUNT_DEF = 65536;
	localparam int PT_W            = 16;
	localparam int TOTAL_W         = 17;
	localparam int IN_W            = 32;
	localparam int OUT_W           = 56;

	// m_tdata field offsets
	localparam int OUT_CODE_LSB  = 0;
	localparam int OUT_HEAD_LSB  = 2;
	localparam int OUT_ADDED_LSB = 18;
	localparam int OUT_TOTAL_LSB = 34;

	typedef enum logic [1:0] {
		OUT_NEW  = 2'd0,
		OUT_JOIN = 2'd1,
		OUT_SKIP = 2'd2,
		OUT_SELF = 2'd3
	} outcome_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_READ,
		ST_LOOK,
		ST_HREAD,
		ST_HLOOK,
		ST_WR1,
		ST_WR2,
		ST_EMIT
	} state_t;

endpackage

[rtl/png_ram.sv]
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module png_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

[rtl/pair_net_grouper.sv]
// Pair net grouper: assigns pairs of connection points to nets in an owner table.
// Each request carries two point indices; every request gives exactly one result.
// The owner table is one RAM word per point (valid, head flag, head index, member
// count) with a registered read on two ports and a single write port. A request
// goes through READ and LOOK, then to EMIT for a self pair or a skip with the first
// point a head, through WR1 and WR2 for a new net, and through HREAD and HLOOK first
// when the net's head must be looked up. REDUCE steps come first when POINT_COUNT is
// not a power of two and below 65536 (up to 15 steps). The two writes of a new net
// or a join go out one per cycle through the single write port. After reset the
// table is cleared one entry per cycle with s_tready low; results are held in an
// output register so the next request can start while one waits.
`timescale 1ns / 1ps
module pair_net_grouper #(
	parameter int POINT_COUNT = png_pkg::POINT_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// [15:0] first_point, [31:16] second_point
	input  logic [png_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [1:0] outcome, [17:2] net_head, [33:18] added_point, [50:34] member_total, rest 0
	output logic [png_pkg::OUT_W-1:0]  m_tdata
);

	localparam int AW        = $clog2(POINT_COUNT);
	localparam int CAP       = (POINT_COUNT > 131071) ? 131071 : POINT_COUNT;
	localparam int CNT_W     = $clog2(CAP + 1);
	localparam int WORD_W    = 2 + AW + CNT_W;
	localparam int HEAD_LSB  = CNT_W;
	localparam int ISH_BIT   = CNT_W + AW;
	localparam int VAL_BIT   = CNT_W + AW + 1;
	localparam int RED_STEPS = (POINT_COUNT >= 65536 ||
		(POINT_COUNT & (POINT_COUNT - 1)) == 0) ? 0 : $clog2(65535 / POINT_COUNT + 1);
	localparam int RW        = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

	function automatic logic [AW-1:0] to_addr(input logic [png_pkg::PT_W-1:0] v);
		logic [31:0] t;
		t = {16'b0, v};
		return t[AW-1:0];
	endfunction

	png_pkg::state_t   state_q, state_d;
	logic [AW-1:0]     clr_q;
	logic [RW-1:0]     red_q;
	logic [png_pkg::PT_W-1:0] a_q, b_q;
	logic [AW-1:0]     head_q, joiner_q;
	logic [CNT_W-1:0]  cnt_q;
	png_pkg::outcome_t outcome_q;
	logic              mvalid_q;
	logic [png_pkg::OUT_W-1:0] mdata_q;

	logic              we;
	logic [AW-1:0]     waddr, raddr_a, raddr_b;
	logic [WORD_W-1:0] wdata, rd_a, rd_b;
	logic              out_load;

	logic [AW-1:0]     a_addr, b_addr;
	logic              self_w, va, vb;
	logic [WORD_W-1:0] rd_e;
	logic              e_is_head;
	logic [CNT_W-1:0]  cnt_src, cnt_inc;
	logic [31:0]       sub_w;
	logic [16:0]       sub_17;

	assign a_addr    = to_addr(a_q);
	assign b_addr    = to_addr(b_q);
	assign self_w    = (a_addr == b_addr);
	assign va        = rd_a[VAL_BIT];
	assign vb        = rd_b[VAL_BIT];
	assign rd_e      = va ? rd_a : rd_b;
	assign e_is_head = rd_e[ISH_BIT];
	assign cnt_src   = (state_q == png_pkg::ST_LOOK) ? rd_e[CNT_W-1:0] : rd_a[CNT_W-1:0];
	assign cnt_inc   = (cnt_src < CNT_W'(CAP)) ? cnt_src + CNT_W'(1) : cnt_src;
	assign sub_w     = 32'(POINT_COUNT) << red_q;
	assign sub_17    = sub_w[16:0];

	png_ram #(
		.WIDTH(WORD_W),
		.DEPTH(POINT_COUNT)
	) u_owner_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rd_a),
		.raddr_b(raddr_b),
		.rdata_b(rd_b)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			png_pkg::ST_CLEAR: begin
				if (clr_q == AW'(POINT_COUNT - 1)) state_d = png_pkg::ST_IDLE;
			end
			png_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = (RED_STEPS > 0) ? png_pkg::ST_REDUCE : png_pkg::ST_READ;
			end
			png_pkg::ST_REDUCE: begin
				if (red_q == '0) state_d = png_pkg::ST_READ;
			end
			png_pkg::ST_READ: state_d = png_pkg::ST_LOOK;
			png_pkg::ST_LOOK: begin
				if (self_w) state_d = png_pkg::ST_EMIT;
				else if (!va && !vb) state_d = png_pkg::ST_WR1;
				else if (!e_is_head) state_d = png_pkg::ST_HREAD;
				else if (va && vb) state_d = png_pkg::ST_EMIT;
				else state_d = png_pkg::ST_WR1;
			end
			png_pkg::ST_HREAD: state_d = png_pkg::ST_HLOOK;
			png_pkg::ST_HLOOK: begin
				state_d = (outcome_q == png_pkg::OUT_SKIP) ? png_pkg::ST_EMIT : png_pkg::ST_WR1;
			end
			png_pkg::ST_WR1: state_d = png_pkg::ST_WR2;
			png_pkg::ST_WR2: state_d = png_pkg::ST_EMIT;
			png_pkg::ST_EMIT: begin
				if (out_load) state_d = png_pkg::ST_IDLE;
			end
			default: state_d = png_pkg::ST_CLEAR;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready = 1'b0;
		we       = 1'b0;
		waddr    = clr_q;
		wdata    = '0;
		raddr_a  = a_addr;
		raddr_b  = b_addr;
		out_load = 1'b0;
		case (state_q)
			png_pkg::ST_CLEAR: begin
				we = 1'b1;
			end
			png_pkg::ST_IDLE: s_tready = 1'b1;
			png_pkg::ST_HREAD: raddr_a = head_q;
			png_pkg::ST_WR1: begin
				we    = 1'b1;
				waddr = head_q;
				wdata = {1'b1, 1'b1, head_q, cnt_q};
			end
			png_pkg::ST_WR2: begin
				we    = 1'b1;
				waddr = joiner_q;
				wdata = {1'b1, 1'b0, head_q, {CNT_W{1'b0}}};
			end
			png_pkg::ST_EMIT: out_load = !mvalid_q || m_tready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= png_pkg::ST_CLEAR;
			clr_q    <= '0;
			mvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			mvalid_q <= out_load | (mvalid_q & ~m_tready);
			if (state_q == png_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			png_pkg::ST_IDLE: begin
				a_q   <= s_tdata[15:0];
				b_q   <= s_tdata[31:16];
				red_q <= RW'(RED_STEPS - 1);
			end
			png_pkg::ST_REDUCE: begin
				if ({1'b0, a_q} >= sub_17) a_q <= a_q - sub_17[15:0];
				if ({1'b0, b_q} >= sub_17) b_q <= b_q - sub_17[15:0];
				red_q <= red_q - RW'(1);
			end
			png_pkg::ST_LOOK: begin
				if (self_w) begin
					outcome_q <= png_pkg::OUT_SELF;
					head_q    <= '0;
					joiner_q  <= '0;
					cnt_q     <= '0;
				end else if (!va && !vb) begin
					outcome_q <= png_pkg::OUT_NEW;
					head_q    <= a_addr;
					joiner_q  <= b_addr;
					cnt_q     <= CNT_W'(2);
				end else begin
					outcome_q <= (va && vb) ? png_pkg::OUT_SKIP : png_pkg::OUT_JOIN;
					joiner_q  <= (va && vb) ? '0 : (va ? b_addr : a_addr);
					if (e_is_head) begin
						head_q <= va ? a_addr : b_addr;
						cnt_q  <= (va && vb) ? cnt_src : cnt_inc;
					end else begin
						head_q <= rd_e[HEAD_LSB +: AW];
					end
				end
			end
			png_pkg::ST_HLOOK: begin
				cnt_q <= (outcome_q == png_pkg::OUT_SKIP) ? cnt_src : cnt_inc;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			mdata_q <= {5'b0, 17'({15'b0, cnt_q}), 16'({16'b0, joiner_q}),
				16'({16'b0, head_q}), outcome_q};
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;

endmodule

[rtl/png_checker.sv]
// Port-level checks for the pair net grouper, bound to the top level.
`timescale 1ns / 1ps
module png_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [png_pkg::IN_W-1:0]  s_tdata,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [png_pkg::OUT_W-1:0] m_tdata
);

	logic [1:0]  code;
	logic [15:0] head, added;
	logic [16:0] total;

	assign code  = m_tdata[png_pkg::OUT_CODE_LSB +: 2];
	assign head  = m_tdata[png_pkg::OUT_HEAD_LSB +: 16];
	assign added = m_tdata[png_pkg::OUT_ADDED_LSB +: 16];
	assign total = m_tdata[png_pkg::OUT_TOTAL_LSB +: png_pkg::TOTAL_W];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in work");

	a_self: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && code == png_pkg::OUT_SELF |-> head == 16'd0 && added == 16'd0 &&
		total == 17'd0)
		else $error("self pair result not zero");

	a_new: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && code == png_pkg::OUT_NEW |-> total == 17'd2 && head != added)
		else $error("new net result malformed");

	a_join: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && code == png_pkg::OUT_JOIN |-> total >= 17'd3 && head != added)
		else $error("join result malformed");

endmodule

bind pair_net_grouper png_checker u_png_checker (.*);
